// File: src/kbq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbq_pkg
// Shared types and constants for the key event qualifier.
// ----------------------------------------------------------------------------
package kbq_pkg;

    // Command codes carried in the input word
    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_PRESS     = 3'd0;
    localparam cmd_t CMD_RELEASE   = 3'd1;
    localparam cmd_t CMD_SHORT     = 3'd2;
    localparam cmd_t CMD_LONG      = 3'd3;
    localparam cmd_t CMD_REPEAT    = 3'd4;
    localparam cmd_t CMD_WATCHDOG  = 3'd5;
    localparam cmd_t CMD_END_FRAME = 3'd6;

    // Configuration register indexes
    typedef logic cfg_idx_t;
    localparam cfg_idx_t CFG_DOUBLE_TAP_WINDOW = 1'b0;
    localparam cfg_idx_t CFG_STUCK_TIMEOUT     = 1'b1;

    // Register reset values
    localparam logic [15:0] DOUBLE_TAP_WINDOW_RST = 16'd300;
    localparam logic [15:0] STUCK_TIMEOUT_RST     = 16'd500;

    // Event broadcast to all key slices
    typedef struct packed {
        logic        upd;   // word leaves the input register this cycle
        cmd_t        cmd;
        logic [31:0] now;
    } kbq_evt_t;

    // Per-key flags after the update
    typedef struct packed {
        logic held;
        logic pressed;
        logic released;
        logic dtap;
        logic armed;
    } kbq_flags_t;

endpackage : kbq_pkg
`default_nettype wire

// File: src/kbq_key_slice.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbq_key_slice
// State and update logic for one key: flags, last press and heartbeat times.
// ----------------------------------------------------------------------------
module kbq_key_slice (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kbq_pkg::kbq_evt_t evt,
    input  wire logic              hit,
    input  wire logic [15:0]       double_tap_window,
    input  wire logic [15:0]       stuck_timeout,
    output kbq_pkg::kbq_flags_t    flags_next
);
    import kbq_pkg::*;

    logic        held_reg, held_next;
    logic        pe_reg, pe_next;
    logic        re_reg, re_next;
    logic        dt_reg, dt_next;
    logic        armed_reg, armed_next;
    logic        pv_reg, pv_next;
    logic [31:0] hb_time_reg, hb_time_next;
    logic [31:0] press_time_reg, press_time_next;

    logic [31:0] press_gap;
    logic [31:0] hb_age;
    logic        tap_in_window;
    logic        hb_stale;

    // wrapping time differences
    assign press_gap     = evt.now - press_time_reg;
    assign hb_age        = evt.now - hb_time_reg;
    assign tap_in_window = press_gap <= {16'd0, double_tap_window};
    assign hb_stale      = hb_age > {16'd0, stuck_timeout};

    // next state per command
    always_comb
    begin
        held_next       = held_reg;
        pe_next         = pe_reg;
        re_next         = re_reg;
        dt_next         = dt_reg;
        armed_next      = armed_reg;
        pv_next         = pv_reg;
        hb_time_next    = hb_time_reg;
        press_time_next = press_time_reg;
        unique case (evt.cmd)
            CMD_PRESS:
            begin
                if (hit)
                begin
                    held_next    = 1'b1;
                    pe_next      = 1'b1;
                    armed_next   = 1'b0;
                    hb_time_next = evt.now;
                    if (pv_reg && tap_in_window)
                    begin
                        dt_next         = 1'b1;
                        pv_next         = 1'b0;
                        press_time_next = '0;
                    end
                    else
                    begin
                        pv_next         = 1'b1;
                        press_time_next = evt.now;
                    end
                end
            end
            CMD_RELEASE:
            begin
                if (hit)
                begin
                    held_next  = 1'b0;
                    re_next    = 1'b1;
                    armed_next = 1'b0;
                end
            end
            CMD_SHORT:
            begin
                if (hit)
                begin
                    if (held_reg)
                    begin
                        held_next = 1'b0;
                        re_next   = 1'b1;
                    end
                    armed_next = 1'b0;
                end
            end
            CMD_LONG, CMD_REPEAT:
            begin
                if (hit && held_reg)
                begin
                    armed_next   = 1'b1;
                    hb_time_next = evt.now;
                end
            end
            CMD_WATCHDOG:
            begin
                // force release of a stuck key
                if (held_reg && armed_reg && hb_stale)
                begin
                    held_next  = 1'b0;
                    re_next    = 1'b1;
                    armed_next = 1'b0;
                end
            end
            CMD_END_FRAME:
            begin
                pe_next = 1'b0;
                re_next = 1'b0;
                dt_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // state registers, updated only when the word moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= 1'b0;
            pe_reg         <= 1'b0;
            re_reg         <= 1'b0;
            dt_reg         <= 1'b0;
            armed_reg      <= 1'b0;
            pv_reg         <= 1'b0;
            hb_time_reg    <= '0;
            press_time_reg <= '0;
        end
        else if (evt.upd)
        begin
            held_reg       <= held_next;
            pe_reg         <= pe_next;
            re_reg         <= re_next;
            dt_reg         <= dt_next;
            armed_reg      <= armed_next;
            pv_reg         <= pv_next;
            hb_time_reg    <= hb_time_next;
            press_time_reg <= press_time_next;
        end
    end

    assign flags_next.held     = held_next;
    assign flags_next.pressed  = pe_next;
    assign flags_next.released = re_next;
    assign flags_next.dtap     = dt_next;
    assign flags_next.armed    = armed_next;

endmodule : kbq_key_slice
`default_nettype wire

// File: src/key_event_qualifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_event_qualifier
// Per-key button qualifier: held, edge, double-tap and stuck-key watchdog.
// ----------------------------------------------------------------------------
// One word is accepted per clock unless in_stall is raised. An accepted word
// sits in the input register while every key slice updates in parallel, and
// its result word is loaded into the output register when the word moves on,
// which waits while the output register holds a stalled result. The rate is
// set by the state update in the key slices; the output register lets a new
// word in while a finished result waits to be taken. Configuration writes are
// always ready and take effect once registered.
module key_event_qualifier #(
    parameter int unsigned KEY_COUNT = 6
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input words
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  command,
    input  wire logic [2:0]  key_index,
    input  wire logic [31:0] now_ms,
    // result words
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       held_mask,
    output logic [5:0]       pressed_mask,
    output logic [5:0]       released_mask,
    output logic [5:0]       double_tap_mask,
    output logic [5:0]       armed_mask,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire kbq_pkg::cfg_idx_t cfg_index,
    input  wire logic [15:0] cfg_data
);
    import kbq_pkg::*;

    logic        s1_valid_reg;
    cmd_t        s1_cmd_reg;
    logic [2:0]  s1_key_reg;
    logic [31:0] s1_now_reg;

    logic        out_valid_reg;
    logic [5:0]  held_reg, pressed_reg, released_reg, dtap_reg, armed_reg;
    logic [5:0]  held_next, pressed_next, released_next, dtap_next, armed_next;

    logic [15:0] dtw_reg;
    logic [15:0] timeout_reg;

    logic        advance;
    logic        in_accept;
    kbq_evt_t    evt;
    kbq_flags_t  flags [KEY_COUNT];

    // handshake
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dtw_reg     <= DOUBLE_TAP_WINDOW_RST;
            timeout_reg <= STUCK_TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DOUBLE_TAP_WINDOW: dtw_reg     <= cfg_data;
                CFG_STUCK_TIMEOUT:     timeout_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg <= command;
            s1_key_reg <= key_index;
            s1_now_reg <= now_ms;
        end
    end

    assign evt.upd = advance;
    assign evt.cmd = s1_cmd_reg;
    assign evt.now = s1_now_reg;

    // one slice per key; an out-of-range key index never matches a slice
    for (genvar k = 0; k < KEY_COUNT; k++)
    begin : g_key
        kbq_key_slice u_slice (
            .clk               (clk),
            .rst_n             (rst_n),
            .evt               (evt),
            .hit               ({1'b0, s1_key_reg} == 4'(k)),
            .double_tap_window (dtw_reg),
            .stuck_timeout     (timeout_reg),
            .flags_next        (flags[k])
        );
    end

    // gather masks; unused key positions read zero
    always_comb
    begin
        held_next     = '0;
        pressed_next  = '0;
        released_next = '0;
        dtap_next     = '0;
        armed_next    = '0;
        for (int unsigned k = 0; k < KEY_COUNT; k++)
        begin
            held_next[k]     = flags[k].held;
            pressed_next[k]  = flags[k].pressed;
            released_next[k] = flags[k].released;
            dtap_next[k]     = flags[k].dtap;
            armed_next[k]    = flags[k].armed;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            held_reg     <= held_next;
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
            dtap_reg     <= dtap_next;
            armed_reg    <= armed_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign held_mask       = held_reg;
    assign pressed_mask    = pressed_reg;
    assign released_mask   = released_reg;
    assign double_tap_mask = dtap_reg;
    assign armed_mask      = armed_reg;

endmodule : key_event_qualifier
`default_nettype wire
